### src/cpc_pkg.sv
// Shared constants, status codes and the rounding helper for the circle pair
// collision resolver. Depends on nothing; the interfaces and the top level use it.
`default_nettype none

package cpc_pkg;

    // Default data format of positions and velocities
    localparam int FRAC_BITS_DEF = 8;
    localparam int POS_WIDTH_DEF = 24;

    // Fixed internal formats
    localparam int NORM_FRAC  = 16;
    localparam int REST_FRAC  = 8;
    localparam int RADIUS_W   = 14;
    localparam int REST_W     = 9;
    localparam int REST_RESET = 205;
    localparam int STATUS_W   = 2;

    // Width of the rounding datapath: wide enough for every product
    localparam int RND_W = 80;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE       = 2'd0,
        ST_COINCIDENT = 2'd1,
        ST_SEPARATED  = 2'd2,
        ST_IMPULSE    = 2'd3
    } contact_t;

    // Drop sh fraction bits, rounding to nearest with ties away from zero
    function automatic logic signed [RND_W-1:0] rnd(
        input logic signed [RND_W-1:0] v,
        input int unsigned             sh
    );
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] res;
        mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        res = (mag + (RND_W'(1) << (sh - 1))) >> sh;
        return v[RND_W-1] ? -$signed(res) : $signed(res);
    endfunction

endpackage

`default_nettype wire

### src/cpc_pair_if.sv
// Input channel of the collision resolver: one circle pair per transfer.
// Depends on cpc_pkg for the default position width and the radius width.
`default_nettype none

interface cpc_pair_if #(
    parameter int POS_WIDTH = cpc_pkg::POS_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [POS_WIDTH-1:0]       pos_a_x;
    logic signed [POS_WIDTH-1:0]       pos_a_y;
    logic signed [POS_WIDTH-1:0]       pos_b_x;
    logic signed [POS_WIDTH-1:0]       pos_b_y;
    logic signed [POS_WIDTH-1:0]       vel_a_x;
    logic signed [POS_WIDTH-1:0]       vel_a_y;
    logic signed [POS_WIDTH-1:0]       vel_b_x;
    logic signed [POS_WIDTH-1:0]       vel_b_y;
    logic [cpc_pkg::RADIUS_W-1:0]      radius_a;
    logic [cpc_pkg::RADIUS_W-1:0]      radius_b;

    modport source (
        output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
               vel_a_x, vel_a_y, vel_b_x, vel_b_y, radius_a, radius_b,
        input  ready
    );

    modport sink (
        input  valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
               vel_a_x, vel_a_y, vel_b_x, vel_b_y, radius_a, radius_b,
        output ready
    );
endinterface

`default_nettype wire

### src/cpc_result_if.sv
// Output channel of the collision resolver: corrected pair and contact status.
// Depends on cpc_pkg for the default position width and the status width.
`default_nettype none

interface cpc_result_if #(
    parameter int POS_WIDTH = cpc_pkg::POS_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [POS_WIDTH-1:0]       new_pos_a_x;
    logic signed [POS_WIDTH-1:0]       new_pos_a_y;
    logic signed [POS_WIDTH-1:0]       new_pos_b_x;
    logic signed [POS_WIDTH-1:0]       new_pos_b_y;
    logic signed [POS_WIDTH-1:0]       new_vel_a_x;
    logic signed [POS_WIDTH-1:0]       new_vel_a_y;
    logic signed [POS_WIDTH-1:0]       new_vel_b_x;
    logic signed [POS_WIDTH-1:0]       new_vel_b_y;
    logic [cpc_pkg::STATUS_W-1:0]      contact_status;

    modport source (
        output valid, new_pos_a_x, new_pos_a_y, new_pos_b_x, new_pos_b_y,
               new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, contact_status,
        input  ready
    );

    modport sink (
        input  valid, new_pos_a_x, new_pos_a_y, new_pos_b_x, new_pos_b_y,
               new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, contact_status,
        output ready
    );
endinterface

`default_nettype wire

### src/cpc_sqrt_cell.sv
// One cell of the square root row: settles one root bit per cycle while en is high.
// No package dependency; chained by the top level.
`default_nettype none

module cpc_sqrt_cell #(
    parameter int SQ_W = 46,
    parameter int J    = 0
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [SQ_W-1:0] v_in,
    input  wire logic [SQ_W-1:0] r_in,
    output logic      [SQ_W-1:0] v_out,
    output logic      [SQ_W-1:0] r_out
);

    localparam logic [SQ_W:0] BIT_VAL = (SQ_W+1)'(1) << (2 * J);

    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] v_next;
    logic [SQ_W-1:0] r_next;
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] r_reg;

    // Test the current root bit against the remainder
    always_comb
    begin
        trial = (SQ_W+1)'(r_in) + BIT_VAL;
        if ((SQ_W+1)'(v_in) >= trial)
        begin
            v_next = SQ_W'((SQ_W+1)'(v_in) - trial);
            r_next = (r_in >> 1) + SQ_W'(BIT_VAL);
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    // Hand on to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

`default_nettype wire

### src/cpc_div_cell.sv
// One cell of a divider row: settles one quotient bit per cycle while en is high.
// No package dependency; chained by the top level.
`default_nettype none

module cpc_div_cell #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 29,
    parameter int Q_W   = 17,
    parameter int BIT   = 0
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] rem_in,
    input  wire logic [DEN_W-1:0] den_in,
    input  wire logic [Q_W-1:0]   q_in,
    output logic      [NUM_W-1:0] rem_out,
    output logic      [DEN_W-1:0] den_out,
    output logic      [Q_W-1:0]   q_out
);

    localparam int W = ((NUM_W > DEN_W + BIT) ? NUM_W : DEN_W + BIT) + 1;

    logic [W-1:0]     dsh;
    logic [NUM_W-1:0] rem_next;
    logic [Q_W-1:0]   q_next;
    logic [NUM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;

    // Subtract the shifted divisor where it fits
    always_comb
    begin
        dsh = W'(den_in) << BIT;
        if (W'(rem_in) >= dsh)
        begin
            rem_next = NUM_W'(W'(rem_in) - dsh);
            q_next   = q_in | (Q_W'(1) << BIT);
        end
        else
        begin
            rem_next = rem_in;
            q_next   = q_in;
        end
    end

    // Hand on to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

### src/circle_pair_collision_resolve.sv
// A pair passes registers s1-s3, the root and divider cell rows, e1-e6 and the output register.
// Throughput: one pair per cycle unless the output stalls; the root cell row and the four divider
// cell rows each take a new operand every cycle, so the rate is set by the single-bit cells,
// not by iteration. A stall on the output freezes the whole pipeline; input ready follows it.
// Reset clears all valid bits and loads restitution with 205; no clearing pass is run.
// Depends on cpc_pkg, cpc_pair_if, cpc_result_if, cpc_sqrt_cell and cpc_div_cell.
`default_nettype none

module circle_pair_collision_resolve #(
    parameter int FRAC_BITS = cpc_pkg::FRAC_BITS_DEF,
    parameter int POS_WIDTH = cpc_pkg::POS_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [cpc_pkg::REST_W-1:0]  cfg_wdata,
    cpc_pair_if.sink                         pair_in,
    cpc_result_if.source                     pair_out
);

    localparam int PW      = POS_WIDTH;
    localparam int NF      = cpc_pkg::NORM_FRAC;
    localparam int RW      = cpc_pkg::RADIUS_W;
    localparam int RND_W   = cpc_pkg::RND_W;
    localparam int SCALE   = NF - FRAC_BITS;
    localparam int unsigned NSH  = 2 * NF - FRAC_BITS;
    localparam int unsigned VSH  = cpc_pkg::REST_FRAC + NF;
    localparam int D_W     = 16;
    localparam int MD_W    = RW + 1;
    localparam int M_W     = 2 * RW;
    localparam int MS_W    = M_W + 1;
    localparam int DSQ_W   = 2 * MD_W + 1;
    localparam int SQ_W    = 2 * MD_W + 2 * SCALE;
    localparam int DIST_W  = SQ_W / 2;
    localparam int OV_W    = DIST_W;
    localparam int Q_W     = NF + 1;
    localparam int NUMX_W  = D_W - 1 + NSH;
    localparam int NUMS_W  = M_W + NF;
    localparam int NUM_W   = (NUMX_W > NUMS_W) ? NUMX_W : NUMS_W;
    localparam int DEN_W   = (DIST_W > MS_W) ? DIST_W : MS_W;
    localparam int RV_W    = PW + 1;
    localparam int NX_W    = Q_W + 1;
    localparam int SH_W    = Q_W;
    localparam int PA_W    = OV_W + SH_W + 1;
    localparam int CA_W    = OV_W + 1;
    localparam int VP_W    = RV_W + NX_W;
    localparam int VN8_W   = VP_W + 2 - NF;
    localparam int K_W     = cpc_pkg::REST_W + 1;
    localparam int KV_W    = VN8_W + K_W + 1;
    localparam int GP_W    = KV_W + SH_W + 1;
    localparam int G_W     = GP_W - NF + 1;
    localparam int CP_W    = NX_W + CA_W;
    localparam int GV_W    = G_W + NX_W;
    localparam int TOTAL   = 3 + DIST_W + Q_W + 7;
    localparam int SQ0     = 3;
    localparam int DV0     = SQ0 + DIST_W;
    localparam int E1      = DV0 + Q_W;
    localparam int LAST    = TOTAL - 1;

    localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) << (PW - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

    typedef struct packed {
        logic [7:0][PW-1:0]        p;
        logic [RW-1:0]             ra;
        logic [RW-1:0]             rb;
        logic                      near;
        logic                      touch;
        logic                      coinc;
        logic                      imp;
        logic                      sgnx;
        logic                      sgny;
        logic signed [D_W-1:0]     dx;
        logic signed [D_W-1:0]     dy;
        logic [MD_W-1:0]           md;
        logic [M_W-1:0]            ma;
        logic [M_W-1:0]            mb;
        logic [MS_W-1:0]           ms;
        logic [2*MD_W-1:0]         mdsq;
        logic [DSQ_W-1:0]          dsq;
        logic signed [RV_W-1:0]    rvx;
        logic signed [RV_W-1:0]    rvy;
        logic [DIST_W-1:0]         root;
        logic [OV_W-1:0]           ov;
        logic signed [NX_W-1:0]    nx;
        logic signed [NX_W-1:0]    ny;
        logic [SH_W-1:0]           sha;
        logic [SH_W-1:0]           shb;
        logic signed [PA_W-1:0]    pa;
        logic signed [PA_W-1:0]    pb;
        logic signed [VP_W-1:0]    vx;
        logic signed [VP_W-1:0]    vy;
        logic signed [CA_W-1:0]    ca;
        logic signed [CA_W-1:0]    cb;
        logic signed [VN8_W-1:0]   vn8;
        logic signed [CP_W-1:0]    cpxa;
        logic signed [CP_W-1:0]    cpya;
        logic signed [CP_W-1:0]    cpxb;
        logic signed [CP_W-1:0]    cpyb;
        logic signed [KV_W-1:0]    kv;
        logic signed [GP_W-1:0]    gpa;
        logic signed [GP_W-1:0]    gpb;
        logic signed [G_W-1:0]     ga;
        logic signed [G_W-1:0]     gb;
        logic signed [GV_W-1:0]    gvxa;
        logic signed [GV_W-1:0]    gvya;
        logic signed [GV_W-1:0]    gvxb;
        logic signed [GV_W-1:0]    gvyb;
        logic [3:0][PW-1:0]        npos;
    } item_t;

    // Clamp to the signed result range
    function automatic logic [PW-1:0] sat_pos(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[PW-1:0];
    endfunction

    function automatic logic signed [RND_W-1:0] wide(input logic [PW-1:0] v);
        return RND_W'($signed(v));
    endfunction

    logic                      adv;
    logic                      accept;
    logic [cpc_pkg::REST_W-1:0] rest_reg;
    logic [TOTAL-1:0]          vld_reg;
    logic [TOTAL-1:0]          vld_next;

    item_t s1_reg, s1_next;
    item_t s2_reg, s2_next;
    item_t s3_reg, s3_next;
    item_t sq_in;
    item_t dv_in;
    item_t sq_item_reg [DIST_W];
    item_t dv_item_reg [Q_W];
    item_t e1_reg, e1_next;
    item_t e2_reg, e2_next;
    item_t e3_reg, e3_next;
    item_t e4_reg, e4_next;
    item_t e5_reg, e5_next;
    item_t e6_reg, e6_next;

    logic [SQ_W-1:0]  sq_v [DIST_W+1];
    logic [SQ_W-1:0]  sq_r [DIST_W+1];
    logic [NUM_W-1:0] dv_rem [4][Q_W+1];
    logic [DEN_W-1:0] dv_den [4][Q_W+1];
    logic [Q_W-1:0]   dv_q   [4][Q_W+1];

    logic [3:0][PW-1:0]  npos_reg;
    logic [3:0][PW-1:0]  nvel_reg;
    logic [3:0][PW-1:0]  nvel_next;
    cpc_pkg::contact_t   status_reg;
    cpc_pkg::contact_t   status_next;

    // Advance the whole pipeline unless the result is held
    assign adv           = !vld_reg[LAST] || pair_out.ready;
    assign accept        = pair_in.valid && adv;
    assign pair_in.ready = adv;

    // Hold the restitution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= cpc_pkg::REST_W'(cpc_pkg::REST_RESET);
        end
        else if (cfg_we)
        begin
            rest_reg <= cfg_wdata;
        end
    end

    // Shift the valid bits along with the data
    assign vld_next = {vld_reg[TOTAL-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture the pair
    always_comb
    begin
        s1_next      = s1_reg;
        s1_next.p[0] = pair_in.pos_a_x;
        s1_next.p[1] = pair_in.pos_a_y;
        s1_next.p[2] = pair_in.pos_b_x;
        s1_next.p[3] = pair_in.pos_b_y;
        s1_next.p[4] = pair_in.vel_a_x;
        s1_next.p[5] = pair_in.vel_a_y;
        s1_next.p[6] = pair_in.vel_b_x;
        s1_next.p[7] = pair_in.vel_b_y;
        s1_next.ra   = pair_in.radius_a;
        s1_next.rb   = pair_in.radius_b;
    end

    // Differences, bounding box test, masses and relative velocities
    always_comb
    begin
        logic signed [RV_W-1:0] dxw;
        logic signed [RV_W-1:0] dyw;
        logic [RV_W-1:0]        adx;
        logic [RV_W-1:0]        ady;
        logic [MD_W-1:0]        md;
        s2_next = s1_reg;
        dxw = RV_W'($signed(s1_reg.p[0])) - RV_W'($signed(s1_reg.p[2]));
        dyw = RV_W'($signed(s1_reg.p[1])) - RV_W'($signed(s1_reg.p[3]));
        adx = dxw[RV_W-1] ? RV_W'(-dxw) : RV_W'(dxw);
        ady = dyw[RV_W-1] ? RV_W'(-dyw) : RV_W'(dyw);
        md  = MD_W'(s1_reg.ra) + MD_W'(s1_reg.rb);
        s2_next.md   = md;
        s2_next.near = (adx < RV_W'(md)) && (ady < RV_W'(md));
        s2_next.dx   = dxw[D_W-1:0];
        s2_next.dy   = dyw[D_W-1:0];
        s2_next.ma   = M_W'(s1_reg.ra) * M_W'(s1_reg.ra);
        s2_next.mb   = M_W'(s1_reg.rb) * M_W'(s1_reg.rb);
        s2_next.mdsq = (2*MD_W)'(md) * (2*MD_W)'(md);
        s2_next.rvx  = RV_W'($signed(s1_reg.p[4])) - RV_W'($signed(s1_reg.p[6]));
        s2_next.rvy  = RV_W'($signed(s1_reg.p[5])) - RV_W'($signed(s1_reg.p[7]));
    end

    // Squared distance and mass sum
    always_comb
    begin
        logic signed [2*D_W-1:0] sqx;
        logic signed [2*D_W-1:0] sqy;
        s3_next = s2_reg;
        sqx = (2*D_W)'(s2_reg.dx) * (2*D_W)'(s2_reg.dx);
        sqy = (2*D_W)'(s2_reg.dy) * (2*D_W)'(s2_reg.dy);
        s3_next.dsq = DSQ_W'(unsigned'(sqx)) + DSQ_W'(unsigned'(sqy));
        s3_next.ms  = MS_W'(s2_reg.ma) + MS_W'(s2_reg.mb);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    // Contact test and root row entry
    always_comb
    begin
        sq_in       = s3_reg;
        sq_in.touch = s3_reg.near && (s3_reg.dsq < DSQ_W'(s3_reg.mdsq));
        sq_in.coinc = sq_in.touch && (s3_reg.dsq == '0);
    end

    assign sq_v[0] = SQ_W'(s3_reg.dsq[2*MD_W-1:0]) << (2 * SCALE);
    assign sq_r[0] = '0;

    for (genvar k = 0; k < DIST_W; k++)
    begin : g_sqrt
        cpc_sqrt_cell #(
            .SQ_W (SQ_W),
            .J    (DIST_W - 1 - k)
        ) u_cell (
            .clk   (clk),
            .en    (adv),
            .v_in  (sq_v[k]),
            .r_in  (sq_r[k]),
            .v_out (sq_v[k+1]),
            .r_out (sq_r[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_item_reg[k] <= (k == 0) ? sq_in : sq_item_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Overlap and divider row entry
    always_comb
    begin
        dv_in      = sq_item_reg[DIST_W-1];
        dv_in.root = sq_r[DIST_W][DIST_W-1:0];
        dv_in.ov   = (OV_W'(sq_item_reg[DIST_W-1].md) << SCALE) - sq_r[DIST_W][DIST_W-1:0];
        dv_in.sgnx = sq_item_reg[DIST_W-1].dx[D_W-1];
        dv_in.sgny = sq_item_reg[DIST_W-1].dy[D_W-1];
    end

    always_comb
    begin
        logic [D_W-1:0] adx;
        logic [D_W-1:0] ady;
        adx = dv_in.sgnx ? D_W'(-dv_in.dx) : D_W'(dv_in.dx);
        ady = dv_in.sgny ? D_W'(-dv_in.dy) : D_W'(dv_in.dy);
        dv_rem[0][0] = NUM_W'(adx[D_W-2:0]) << NSH;
        dv_rem[1][0] = NUM_W'(ady[D_W-2:0]) << NSH;
        dv_rem[2][0] = NUM_W'(dv_in.mb) << NF;
        dv_rem[3][0] = NUM_W'(dv_in.ma) << NF;
        dv_den[0][0] = DEN_W'(dv_in.root);
        dv_den[1][0] = DEN_W'(dv_in.root);
        dv_den[2][0] = DEN_W'(dv_in.ms);
        dv_den[3][0] = DEN_W'(dv_in.ms);
        dv_q[0][0]   = '0;
        dv_q[1][0]   = '0;
        dv_q[2][0]   = '0;
        dv_q[3][0]   = '0;
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_div_row
        for (genvar k = 0; k < Q_W; k++)
        begin : g_div
            cpc_div_cell #(
                .NUM_W (NUM_W),
                .DEN_W (DEN_W),
                .Q_W   (Q_W),
                .BIT   (Q_W - 1 - k)
            ) u_cell (
                .clk     (clk),
                .en      (adv),
                .rem_in  (dv_rem[c][k]),
                .den_in  (dv_den[c][k]),
                .q_in    (dv_q[c][k]),
                .rem_out (dv_rem[c][k+1]),
                .den_out (dv_den[c][k+1]),
                .q_out   (dv_q[c][k+1])
            );
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div_item
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_item_reg[k] <= (k == 0) ? dv_in : dv_item_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Normal, shares and first products
    always_comb
    begin
        logic signed [NX_W-1:0] qx;
        logic signed [NX_W-1:0] qy;
        e1_next = dv_item_reg[Q_W-1];
        qx = $signed({1'b0, dv_q[0][Q_W]});
        qy = $signed({1'b0, dv_q[1][Q_W]});
        e1_next.nx  = e1_next.sgnx ? -qx : qx;
        e1_next.ny  = e1_next.sgny ? -qy : qy;
        e1_next.sha = dv_q[2][Q_W];
        e1_next.shb = dv_q[3][Q_W];
        e1_next.pa  = PA_W'($signed({1'b0, e1_next.ov})) * PA_W'($signed({1'b0, e1_next.sha}));
        e1_next.pb  = PA_W'($signed({1'b0, e1_next.ov})) * PA_W'($signed({1'b0, e1_next.shb}));
        e1_next.vx  = VP_W'(e1_next.rvx) * VP_W'(e1_next.nx);
        e1_next.vy  = VP_W'(e1_next.rvy) * VP_W'(e1_next.ny);
    end

    // Round corrections and normal velocity
    always_comb
    begin
        logic signed [RND_W-1:0] vn;
        e2_next = e1_reg;
        e2_next.ca  = CA_W'(cpc_pkg::rnd(RND_W'(e1_reg.pa), NF));
        e2_next.cb  = CA_W'(cpc_pkg::rnd(RND_W'(e1_reg.pb), NF));
        vn = RND_W'(e1_reg.vx) + RND_W'(e1_reg.vy);
        e2_next.vn8 = VN8_W'(cpc_pkg::rnd(vn, NF));
        e2_next.imp = (vn <= 0);
    end

    // Position products and restitution scaling
    always_comb
    begin
        logic [K_W-1:0] k;
        e3_next = e2_reg;
        k = (K_W'(1) << cpc_pkg::REST_FRAC) + K_W'(rest_reg);
        e3_next.cpxa = CP_W'(e2_reg.nx) * CP_W'(e2_reg.ca);
        e3_next.cpya = CP_W'(e2_reg.ny) * CP_W'(e2_reg.ca);
        e3_next.cpxb = CP_W'(e2_reg.nx) * CP_W'(e2_reg.cb);
        e3_next.cpyb = CP_W'(e2_reg.ny) * CP_W'(e2_reg.cb);
        e3_next.kv   = KV_W'($signed({1'b0, k})) * KV_W'(e2_reg.vn8);
    end

    // Corrected positions and impulse products
    always_comb
    begin
        e4_next = e3_reg;
        e4_next.npos[0] = sat_pos(wide(e3_reg.p[0]) + cpc_pkg::rnd(RND_W'(e3_reg.cpxa), NSH));
        e4_next.npos[1] = sat_pos(wide(e3_reg.p[1]) + cpc_pkg::rnd(RND_W'(e3_reg.cpya), NSH));
        e4_next.npos[2] = sat_pos(wide(e3_reg.p[2]) - cpc_pkg::rnd(RND_W'(e3_reg.cpxb), NSH));
        e4_next.npos[3] = sat_pos(wide(e3_reg.p[3]) - cpc_pkg::rnd(RND_W'(e3_reg.cpyb), NSH));
        e4_next.gpa = GP_W'(e3_reg.kv) * GP_W'($signed({1'b0, e3_reg.sha}));
        e4_next.gpb = GP_W'(e3_reg.kv) * GP_W'($signed({1'b0, e3_reg.shb}));
    end

    // Round impulses
    always_comb
    begin
        e5_next = e4_reg;
        e5_next.ga = G_W'(cpc_pkg::rnd(RND_W'(e4_reg.gpa), NF));
        e5_next.gb = G_W'(cpc_pkg::rnd(RND_W'(e4_reg.gpb), NF));
    end

    // Velocity change products
    always_comb
    begin
        e6_next = e5_reg;
        e6_next.gvxa = GV_W'(e5_reg.ga) * GV_W'(e5_reg.nx);
        e6_next.gvya = GV_W'(e5_reg.ga) * GV_W'(e5_reg.ny);
        e6_next.gvxb = GV_W'(e5_reg.gb) * GV_W'(e5_reg.nx);
        e6_next.gvyb = GV_W'(e5_reg.gb) * GV_W'(e5_reg.ny);
    end

    // Final velocities and status
    always_comb
    begin
        nvel_next[0] = sat_pos(wide(e6_reg.p[4]) - cpc_pkg::rnd(RND_W'(e6_reg.gvxa), VSH));
        nvel_next[1] = sat_pos(wide(e6_reg.p[5]) - cpc_pkg::rnd(RND_W'(e6_reg.gvya), VSH));
        nvel_next[2] = sat_pos(wide(e6_reg.p[6]) + cpc_pkg::rnd(RND_W'(e6_reg.gvxb), VSH));
        nvel_next[3] = sat_pos(wide(e6_reg.p[7]) + cpc_pkg::rnd(RND_W'(e6_reg.gvyb), VSH));
        priority if (!e6_reg.touch)
        begin
            status_next = cpc_pkg::ST_NONE;
        end
        else if (e6_reg.coinc)
        begin
            status_next = cpc_pkg::ST_COINCIDENT;
        end
        else if (e6_reg.imp)
        begin
            status_next = cpc_pkg::ST_IMPULSE;
        end
        else
        begin
            status_next = cpc_pkg::ST_SEPARATED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
            e4_reg <= e4_next;
            e5_reg <= e5_next;
            e6_reg <= e6_next;
            for (int i = 0; i < 4; i++)
            begin
                npos_reg[i] <= (status_next == cpc_pkg::ST_SEPARATED ||
                                status_next == cpc_pkg::ST_IMPULSE) ?
                               e6_reg.npos[i] : e6_reg.p[i];
                nvel_reg[i] <= (status_next == cpc_pkg::ST_IMPULSE) ?
                               nvel_next[i] : e6_reg.p[4 + i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= cpc_pkg::ST_NONE;
        end
        else if (adv)
        begin
            status_reg <= status_next;
        end
    end

    // Drive the result channel
    assign pair_out.valid          = vld_reg[LAST];
    assign pair_out.new_pos_a_x    = npos_reg[0];
    assign pair_out.new_pos_a_y    = npos_reg[1];
    assign pair_out.new_pos_b_x    = npos_reg[2];
    assign pair_out.new_pos_b_y    = npos_reg[3];
    assign pair_out.new_vel_a_x    = nvel_reg[0];
    assign pair_out.new_vel_a_y    = nvel_reg[1];
    assign pair_out.new_vel_b_x    = nvel_reg[2];
    assign pair_out.new_vel_b_y    = nvel_reg[3];
    assign pair_out.contact_status = status_reg;

`ifndef NO_ASSERTIONS
    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> vld_reg[0])
        else $error("accepted pair did not enter the pipeline");

    a_no_loss : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[LAST-1]) |=> vld_reg[LAST])
        else $error("pair lost on the way to the output register");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LAST] && !pair_out.ready) |=> (vld_reg[LAST] && $stable(status_reg)))
        else $error("held result changed");

    a_root_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[E1 - 1] && dv_item_reg[Q_W-1].touch && !dv_item_reg[Q_W-1].coinc)
        |-> (dv_item_reg[Q_W-1].root >= (DIST_W'(1) << SCALE)))
        else $error("distance root below one for separated centres");
`endif

endmodule

`default_nettype wire
